/* hdl/ils_pkg.sv */
// Shared types, codes and constants for the indexed list store.
package ils_pkg;

    // Default number of list entries
    localparam int ILS_DEPTH = 64;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the stream format
    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Command codes on the input stream
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes on the output stream
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Storage action the back end carries out
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                op;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   value;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } item_t;

endpackage

/* hdl/ils_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ils_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ils_front.sv */
// Front end: accepts commands, checks them against the running count, classifies them.
module ils_front
    import ils_pkg::*;
#(
    parameter int DEPTH = ILS_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [POS_W-1:0]  s_pos,
    input  logic [VAL_W-1:0]  s_value,
    output logic              q_valid,
    input  logic              q_ready,
    output item_t             q_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CW-1:0]    pos_ext;
    logic [CW-1:0]    cnt_ext;
    logic [CW-1:0]    new_ext;
    logic             full;
    logic             in_range;
    logic             push;

    assign push     = s_tvalid && q_ready;
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;

    assign pos_ext  = {{(CW - POS_W){1'b0}}, s_pos};
    assign cnt_ext  = {{(CW - CNT_W){1'b0}}, count_reg};
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign in_range = (pos_ext < cnt_ext);

    // Classify the command and project the count it leaves behind
    always_comb
    begin
        count_next    = count_reg;
        q_item.op     = OP_NONE;
        q_item.pos    = s_pos;
        q_item.value  = s_value;
        q_item.status = ST_OK;
        case (s_cmd)
            CMD_APPEND:
            begin
                if (full)
                begin
                    q_item.status = ST_FULL;
                end
                else
                begin
                    q_item.op  = OP_APPEND;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    q_item.op = OP_READ;
                end
                else
                begin
                    q_item.status = ST_RANGE;
                end
            end
            CMD_REMOVE:
            begin
                if (in_range)
                begin
                    q_item.op  = OP_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    q_item.status = ST_RANGE;
                end
            end
            default:
            begin
                q_item.op = OP_NONE;
            end
        endcase
        new_ext      = {{(CW - CNT_W){1'b0}}, count_next};
        q_item.count = new_ext[COUNT_W-1:0];
    end

    // Advance the projected count on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/ils_queue.sv */
// Short queue of classified commands between front and back ends.
module ils_queue
    import ils_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int QD   = QUEUE_DEPTH;
    localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
    localparam int FW   = $clog2(QD + 1);

    item_t          slots [QD];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [FW-1:0]  fill_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (fill_reg != FW'(QD));
    assign out_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slots[rd_ptr_reg];

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

/* hdl/ils_back.sv */
// Back end: carries out appends, reads and removes on the entry RAM and drives results.
module ils_back
    import ils_pkg::*;
#(
    parameter int DEPTH = ILS_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  item_t              q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VAL_W-1:0]   m_value,
    output logic [STAT_W-1:0]  m_status,
    output logic [COUNT_W-1:0] m_count
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW1    = CNT_W + 1;
    localparam int PW     = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   bcount_reg;
    logic [CNT_W-1:0]   bcount_next;
    logic [ADDR_W-1:0]  widx_reg;
    logic [ADDR_W-1:0]  widx_next;
    item_t              entry_reg;
    item_t              entry_next;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               slot_free;
    logic               pop;
    logic               res_load;
    logic [VAL_W-1:0]   res_value;
    logic [STAT_W-1:0]  res_status;
    logic [COUNT_W-1:0] res_count;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    logic [PW-1:0]      q_pos_ext;
    logic [ADDR_W-1:0]  q_pos;
    logic [CW1-1:0]     widx_ext;
    logic [CW1-1:0]     bcount_ext;

    assign slot_free  = !out_valid_reg || m_tready;
    assign pop        = (state_reg == S_IDLE) && q_valid && slot_free;
    assign q_ready    = (state_reg == S_IDLE) && slot_free;
    assign q_pos_ext  = {{(PW - POS_W){1'b0}}, q_item.pos};
    assign q_pos      = q_pos_ext[ADDR_W-1:0];
    assign widx_ext   = {{(CW1 - ADDR_W){1'b0}}, widx_reg};
    assign bcount_ext = {1'b0, bcount_reg};

    ils_ram
    #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence each command over the RAM and load its result
    always_comb
    begin
        state_next  = state_reg;
        bcount_next = bcount_reg;
        widx_next   = widx_reg;
        entry_next  = entry_reg;
        ram_we      = 1'b0;
        ram_waddr   = widx_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = q_pos;
        res_load    = 1'b0;
        res_value   = '0;
        res_status  = q_item.status;
        res_count   = q_item.count;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    entry_next = q_item;
                    case (q_item.op)
                        OP_APPEND:
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = bcount_reg[ADDR_W-1:0];
                            ram_wdata   = q_item.value;
                            bcount_next = bcount_reg + CNT_W'(1);
                            res_load    = 1'b1;
                        end
                        OP_READ, OP_REMOVE:
                        begin
                            ram_raddr  = q_pos;
                            widx_next  = q_pos;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load   = 1'b1;
                res_value  = ram_rdata;
                res_status = entry_reg.status;
                res_count  = entry_reg.count;
                state_next = S_IDLE;
                if (entry_reg.op == OP_REMOVE)
                begin
                    if (widx_ext + CW1'(1) < bcount_ext)
                    begin
                        ram_raddr  = widx_reg + ADDR_W'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        bcount_next = bcount_reg - CNT_W'(1);
                    end
                end
            end
            S_SHIFT:
            begin
                // Move the entry above down by one place
                ram_we    = 1'b1;
                ram_waddr = widx_reg;
                ram_wdata = ram_rdata;
                widx_next = widx_reg + ADDR_W'(1);
                if (widx_ext + CW1'(2) < bcount_ext)
                begin
                    ram_raddr = widx_reg + ADDR_W'(2);
                end
                else
                begin
                    bcount_next = bcount_reg - CNT_W'(1);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bcount_reg <= bcount_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        widx_reg  <= widx_next;
        entry_reg <= entry_next;
        if (res_load)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_count_reg  <= res_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_status = out_status_reg;
    assign m_count  = out_count_reg;

    // Stored count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n) bcount_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // An append reaches the back only when there is room
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.op == OP_APPEND) |-> (bcount_reg != CNT_W'(DEPTH)))
        else $error("append issued to a full store");

    // A remove reaches the back only when there are entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.op == OP_REMOVE) |-> (bcount_reg != '0))
        else $error("remove issued to an empty store");

    // A shift step always moves an entry that is inside the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (widx_ext + CW1'(1) < bcount_ext))
        else $error("shift step beyond the list tail");

    // A new result never overwrites one that was not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && out_valid_reg) |-> m_tready)
        else $error("result overwritten before it was taken");

endmodule

/* hdl/indexed_list_store.sv */
// Top level of the indexed list store: front end, command queue and back end.
// The store keeps an ordered list of up to DEPTH signed 32-bit values. Each command appends a
// value at the tail, reads the value at a position, or removes the value at a position and
// closes the gap; every command returns exactly one result carrying the value read or removed
// (zero otherwise), a status (ok, position out of range, store full) and the entry count after
// the command. The front end takes one command per cycle while its two-entry queue has room and
// does all range and capacity checks there; the back end works through the queue on an
// entry RAM with one write port, one read port and registered read. In the back end an append, a
// refused command or an unused code ends in the idle state, a read goes through the idle and read
// states, and a remove adds a shift step per entry above it, as the RAM moves one entry down per
// cycle. A finished result waits in an output register; the back end takes its next command only
// when that register is empty or its beat is taken in the same cycle, so a stalled result side
// holds the back end and, once the queue is full, the input side as well.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int DEPTH = ILS_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] position, [37:6] value_in, [39:38] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value_out, [38:32] count, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic               q_in_valid;
    logic               q_in_ready;
    item_t              q_in_item;
    logic               q_out_valid;
    logic               q_out_ready;
    item_t              q_out_item;
    logic [VAL_W-1:0]   res_value;
    logic [STAT_W-1:0]  res_status;
    logic [COUNT_W-1:0] res_count;

    ils_front
    #(
        .DEPTH (DEPTH)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[CMD_W-1:0]),
        .s_pos    (s_tdata[POS_W-1:0]),
        .s_value  (s_tdata[POS_W+VAL_W-1:POS_W]),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_item   (q_in_item)
    );

    ils_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    ils_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_out_valid),
        .q_ready  (q_out_ready),
        .q_item   (q_out_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (res_value),
        .m_status (res_status),
        .m_count  (res_count)
    );

    // Pack the result beat
    assign m_tdata = {1'b0, res_count, res_value};
    assign m_tuser = res_status;

endmodule
